### rtl/bpe_pkg.sv
// Shared types and constants for the B-spline point evaluation core.
// No dependencies; the divider, controller, datapath, top level and testbench import this package.
`default_nettype none

package bpe_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int MAX_DEGREE_DEF = 5;

    // curve accumulator: up to 64 terms of 34 bits each
    localparam int ACC_W = 48;

    localparam logic signed [31:0] BASIS_ONE = 32'sh4000_0000;
    localparam logic signed [31:0] BASIS_LIM = 32'sh7FFF_FFFF;

    typedef enum logic [1:0] {
        MODE_POINT = 2'd0,
        MODE_KNOT  = 2'd1,
        MODE_EVAL  = 2'd2
    } t_mode;

    typedef enum logic {
        CFG_DEGREE     = 1'b0,
        CFG_NUM_POINTS = 1'b1
    } t_cfg_reg;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_CAP_LO,
        OP_CAP_HI,
        OP_RANGE,
        OP_INIT_WR,
        OP_DIV_GO,
        OP_MUL,
        OP_BAS_WR,
        OP_TERM_MUL,
        OP_TERM_ACC,
        OP_RESULT
    } t_dp_op;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RNG_RD,
        ST_RNG_CAP,
        ST_RNG_CHK,
        ST_INIT_RD,
        ST_INIT_CAP,
        ST_INIT_WR,
        ST_STEP_RDA,
        ST_STEP_CAPA,
        ST_STEP_CAPB,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_MUL,
        ST_BAS_WR,
        ST_TERM_RD,
        ST_TERM_MUL,
        ST_TERM_ACC,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic in_lo;     // lo knot <= t < hi knot
        logic div_busy;
        logic out_full;
    } t_dp_status;

endpackage

`default_nettype wire

### rtl/bpe_in_if.sv
// Input channel: one beat is a load or an evaluate request.
// Stand-alone interface, no dependencies.
`default_nettype none

interface bpe_in_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  mode;
    logic        [6:0]  index;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic        [31:0] knot_value;
    logic        [31:0] eval_time;

    modport source (
        output valid, mode, index, point_x, point_y, point_z, knot_value, eval_time,
        input  ready
    );
    modport sink (
        input  valid, mode, index, point_x, point_y, point_z, knot_value, eval_time,
        output ready
    );
endinterface

`default_nettype wire

### rtl/bpe_out_if.sv
// Output channel: one beat is one evaluated curve point.
// Stand-alone interface, no dependencies.
`default_nettype none

interface bpe_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] curve_x;
    logic signed [31:0] curve_y;
    logic signed [31:0] curve_z;
    logic               in_range;

    modport source (
        output valid, curve_x, curve_y, curve_z, in_range,
        input  ready
    );
    modport sink (
        input  valid, curve_x, curve_y, curve_z, in_range,
        output ready
    );
endinterface

`default_nettype wire

### rtl/bpe_div.sv
// Radix-2 restoring divider for the Q.30 knot ratio (num * 2^30) / den.
// Truncates toward zero, clamps to +-(2^31-1), zero divisor gives 0. Uses bpe_pkg.
`default_nettype none

module bpe_div
    import bpe_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [32:0] i_num,
    input  wire logic signed [32:0] i_den,
    output logic                    o_busy,
    output logic signed [31:0]      o_quot
);

    logic               r_busy;
    logic        [4:0]  r_cnt;
    logic        [31:0] r_rem;
    logic        [30:0] r_q;
    logic        [31:0] r_d;
    logic               r_lsb;
    logic               r_neg;
    logic signed [31:0] r_quot;

    logic signed [32:0] w_nneg;
    logic signed [32:0] w_dneg;
    logic        [31:0] w_mag_n;
    logic        [31:0] w_mag_d;
    logic               w_over;
    logic        [32:0] w_shift;
    logic               w_ge;
    logic        [32:0] w_sub;
    logic        [30:0] w_qn;
    logic signed [31:0] w_qv;

    always_comb begin
        w_nneg  = -i_num;
        w_dneg  = -i_den;
        w_mag_n = i_num[32] ? w_nneg[31:0] : i_num[31:0];
        w_mag_d = i_den[32] ? w_dneg[31:0] : i_den[31:0];
        // quotient reaches 2^31 exactly when |num| >= 2|den|
        w_over  = {1'b0, w_mag_n} >= {w_mag_d, 1'b0};
        w_shift = {r_rem, (r_cnt == 5'd30) ? r_lsb : 1'b0};
        w_ge    = w_shift >= {1'b0, r_d};
        w_sub   = w_shift - {1'b0, r_d};
        w_qn    = {r_q[29:0], w_ge};
        w_qv    = $signed({1'b0, w_qn});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            if (i_den == 33'sd0) begin
                r_quot <= '0;
            end else if (w_over) begin
                r_quot <= (i_num[32] ^ i_den[32]) ? -BASIS_LIM : BASIS_LIM;
            end else begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd30;
                r_rem  <= {1'b0, w_mag_n[31:1]};
                r_lsb  <= w_mag_n[0];
                r_d    <= w_mag_d;
                r_neg  <= i_num[32] ^ i_den[32];
                r_q    <= '0;
            end
        end else if (r_busy) begin
            r_rem <= w_ge ? w_sub[31:0] : w_shift[31:0];
            r_q   <= w_qn;
            if (r_cnt == 5'd0) begin
                r_busy <= 1'b0;
                r_quot <= r_neg ? -w_qv : w_qv;
            end else begin
                r_cnt <= r_cnt - 5'd1;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

### rtl/bpe_ctrl.sv
// Sequencer for the evaluation: config registers, loop counters, datapath commands.
// Uses bpe_pkg; drives bpe_datapath.
`default_nettype none

module bpe_ctrl
    import bpe_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int MAX_DEGREE = MAX_DEGREE_DEF,
    localparam int KNOT_DEPTH = MAX_POINTS + MAX_DEGREE + 1,
    localparam int KW = $clog2(KNOT_DEPTH),
    localparam int CW = $clog2(KNOT_DEPTH + 1)
)(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic          i_cfg_addr,
    input  wire logic [6:0]    i_cfg_data,
    input  wire logic          i_in_valid,
    input  wire logic [1:0]    i_in_mode,
    output logic               o_in_ready,
    input  wire t_dp_status    i_status,
    output t_dp_op             o_op,
    output logic [KW-1:0]      o_ka,
    output logic [KW-1:0]      o_kb,
    output logic [KW-1:0]      o_j
);

    logic [2:0]    r_degree;
    logic [6:0]    r_num_points;
    t_state        r_state, n_state;
    logic [CW-1:0] r_j, n_j;
    logic [2:0]    r_p, n_p;

    logic [2:0]    w_k;
    logic [CW-1:0] w_n;
    logic [CW-1:0] w_nk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree     <= 3'd3;
            r_num_points <= 7'd4;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_DEGREE:     r_degree     <= i_cfg_data[2:0];
                CFG_NUM_POINTS: r_num_points <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (int'(r_degree) > MAX_DEGREE) w_k = 3'(MAX_DEGREE);
        else                             w_k = r_degree;
        if (r_num_points == 7'd0)                 w_n = CW'(1);
        else if (int'(r_num_points) > MAX_POINTS) w_n = CW'(MAX_POINTS);
        else                                      w_n = CW'(r_num_points);
        w_nk = w_n + CW'(w_k);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_j     <= '0;
            r_p     <= '0;
        end else begin
            r_state <= n_state;
            r_j     <= n_j;
            r_p     <= n_p;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_j        = r_j;
        n_p        = r_p;
        o_op       = OP_NOP;
        o_in_ready = 1'b0;
        o_ka       = KW'(r_j);
        o_kb       = KW'(r_j + CW'(r_p));
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_op = OP_ACCEPT;
                    if (i_in_mode == MODE_EVAL) n_state = ST_RNG_RD;
                end
            end
            ST_RNG_RD: begin
                o_ka    = '0;
                o_kb    = KW'(w_nk);
                n_state = ST_RNG_CAP;
            end
            ST_RNG_CAP: begin
                o_op    = OP_CAP_LO;
                n_state = ST_RNG_CHK;
            end
            ST_RNG_CHK: begin
                o_op = OP_RANGE;
                n_j  = '0;
                if (i_status.in_lo) n_state = ST_INIT_RD;
                else                n_state = ST_RESULT;
            end
            ST_INIT_RD: begin
                o_kb    = KW'(r_j + CW'(1));
                n_state = ST_INIT_CAP;
            end
            ST_INIT_CAP: begin
                o_op    = OP_CAP_LO;
                n_state = ST_INIT_WR;
            end
            ST_INIT_WR: begin
                o_op = OP_INIT_WR;
                if (r_j + CW'(1) == w_nk) begin
                    n_j = '0;
                    if (w_k == 3'd0) begin
                        n_state = ST_TERM_RD;
                    end else begin
                        n_p     = 3'd1;
                        n_state = ST_STEP_RDA;
                    end
                end else begin
                    n_j     = r_j + CW'(1);
                    n_state = ST_INIT_RD;
                end
            end
            ST_STEP_RDA: begin
                n_state = ST_STEP_CAPA;
            end
            ST_STEP_CAPA: begin
                o_op    = OP_CAP_LO;
                o_ka    = KW'(r_j + CW'(1));
                o_kb    = KW'(r_j + CW'(r_p) + CW'(1));
                n_state = ST_STEP_CAPB;
            end
            ST_STEP_CAPB: begin
                o_op    = OP_CAP_HI;
                n_state = ST_DIV_GO;
            end
            ST_DIV_GO: begin
                o_op    = OP_DIV_GO;
                n_state = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (!i_status.div_busy) n_state = ST_MUL;
            end
            ST_MUL: begin
                o_op    = OP_MUL;
                n_state = ST_BAS_WR;
            end
            ST_BAS_WR: begin
                o_op    = OP_BAS_WR;
                n_state = ST_STEP_RDA;
                if (r_j + CW'(r_p) + CW'(1) == w_nk) begin
                    n_j = '0;
                    if (r_p == w_k) n_state = ST_TERM_RD;
                    else            n_p     = r_p + 3'd1;
                end else begin
                    n_j = r_j + CW'(1);
                end
            end
            ST_TERM_RD: begin
                n_state = ST_TERM_MUL;
            end
            ST_TERM_MUL: begin
                o_op    = OP_TERM_MUL;
                n_state = ST_TERM_ACC;
            end
            ST_TERM_ACC: begin
                o_op = OP_TERM_ACC;
                if (r_j + CW'(1) == w_n) begin
                    n_state = ST_RESULT;
                end else begin
                    n_j     = r_j + CW'(1);
                    n_state = ST_TERM_RD;
                end
            end
            ST_RESULT: begin
                if (!i_status.out_full) begin
                    o_op    = OP_RESULT;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_j = KW'(r_j);

endmodule

`default_nettype wire

### rtl/bpe_datapath.sv
// Datapath: point, knot and basis stores, two ratio dividers, multipliers,
// accumulators and the output register. Uses bpe_pkg and bpe_div.
`default_nettype none

module bpe_datapath
    import bpe_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int MAX_DEGREE = MAX_DEGREE_DEF,
    localparam int KNOT_DEPTH = MAX_POINTS + MAX_DEGREE + 1,
    localparam int KW = $clog2(KNOT_DEPTH),
    localparam int PW = $clog2(MAX_POINTS)
)(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_dp_op             i_op,
    input  wire logic [KW-1:0]      i_ka,
    input  wire logic [KW-1:0]      i_kb,
    input  wire logic [KW-1:0]      i_j,
    input  wire logic [1:0]         i_mode,
    input  wire logic [6:0]         i_index,
    input  wire logic signed [31:0] i_point_x,
    input  wire logic signed [31:0] i_point_y,
    input  wire logic signed [31:0] i_point_z,
    input  wire logic [31:0]        i_knot_value,
    input  wire logic [31:0]        i_eval_time,
    output t_dp_status              o_status,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [31:0]      o_curve_x,
    output logic signed [31:0]      o_curve_y,
    output logic signed [31:0]      o_curve_z,
    output logic                    o_in_range
);

    logic        [31:0] knot_mem [KNOT_DEPTH];
    logic signed [31:0] bas_mem  [KNOT_DEPTH];
    logic signed [31:0] px_mem   [MAX_POINTS];
    logic signed [31:0] py_mem   [MAX_POINTS];
    logic signed [31:0] pz_mem   [MAX_POINTS];

    logic        [31:0] r_ka, r_kb;
    logic signed [31:0] r_ba, r_bb;
    logic signed [31:0] r_px, r_py, r_pz;
    logic        [31:0] r_t;
    logic        [31:0] r_u0, r_u1, r_u2, r_u3;
    logic signed [31:0] r_b0, r_b1;
    logic signed [63:0] r_p1, r_p2;
    logic signed [63:0] r_mx, r_my, r_mz;
    logic signed [ACC_W-1:0] r_ax, r_ay, r_az;
    logic               r_in_range;
    logic               r_out_valid;
    logic signed [31:0] r_cx, r_cy, r_cz;
    logic               r_out_rng;

    logic signed [32:0] w_num1, w_den1, w_num2, w_den2;
    logic signed [31:0] w_r1, w_r2;
    logic               w_busy1, w_busy2;
    logic               w_div_go;
    logic               w_in_lo;
    logic signed [65:0] w_acc, w_acc_sh;
    logic signed [31:0] w_bas_new;
    logic signed [31:0] w_bas_wd;
    logic               w_bas_we;
    logic signed [65:0] w_tx, w_ty, w_tz;
    logic [KW-1:0]      w_j1;

    assign w_j1 = i_j + KW'(1);

    // loads
    always_ff @(posedge i_clk) begin
        if (i_op == OP_ACCEPT && i_mode == MODE_POINT && int'(i_index) < MAX_POINTS) begin
            px_mem[PW'(i_index)] <= i_point_x;
            py_mem[PW'(i_index)] <= i_point_y;
            pz_mem[PW'(i_index)] <= i_point_z;
        end
        r_px <= px_mem[PW'(i_j)];
        r_py <= py_mem[PW'(i_j)];
        r_pz <= pz_mem[PW'(i_j)];
    end

    always_ff @(posedge i_clk) begin
        if (i_op == OP_ACCEPT && i_mode == MODE_KNOT && int'(i_index) < KNOT_DEPTH) begin
            knot_mem[KW'(i_index)] <= i_knot_value;
        end
        r_ka <= knot_mem[i_ka];
        r_kb <= knot_mem[i_kb];
    end

    always_ff @(posedge i_clk) begin
        if (w_bas_we) begin
            bas_mem[i_j] <= w_bas_wd;
        end
        r_ba <= bas_mem[i_j];
        r_bb <= bas_mem[w_j1];
    end

    always_comb begin
        w_in_lo  = (r_u0 <= r_t) && (r_t < r_u1);
        w_num1   = $signed({1'b0, r_t})  - $signed({1'b0, r_u0});
        w_den1   = $signed({1'b0, r_u1}) - $signed({1'b0, r_u0});
        w_num2   = $signed({1'b0, r_u3}) - $signed({1'b0, r_t});
        w_den2   = $signed({1'b0, r_u3}) - $signed({1'b0, r_u2});
        w_div_go = (i_op == OP_DIV_GO);

        // r1*N1 + r2*N2, round, floor shift, clamp
        w_acc    = 66'(r_p1) + 66'(r_p2) + 66'sd536870912;
        w_acc_sh = w_acc >>> 30;
        if (w_acc_sh > 66'(BASIS_LIM))       w_bas_new = BASIS_LIM;
        else if (w_acc_sh < -66'(BASIS_LIM)) w_bas_new = -BASIS_LIM;
        else                                 w_bas_new = w_acc_sh[31:0];

        w_bas_we = (i_op == OP_INIT_WR) || (i_op == OP_BAS_WR);
        if (i_op == OP_INIT_WR) w_bas_wd = w_in_lo ? BASIS_ONE : 32'sd0;
        else                    w_bas_wd = w_bas_new;

        w_tx = (66'(r_mx) + 66'sd536870912) >>> 30;
        w_ty = (66'(r_my) + 66'sd536870912) >>> 30;
        w_tz = (66'(r_mz) + 66'sd536870912) >>> 30;
    end

    bpe_div u_div1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_go),
        .i_num   (w_num1),
        .i_den   (w_den1),
        .o_busy  (w_busy1),
        .o_quot  (w_r1)
    );

    bpe_div u_div2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_go),
        .i_num   (w_num2),
        .i_den   (w_den2),
        .o_busy  (w_busy2),
        .o_quot  (w_r2)
    );

    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_ACCEPT: begin
                r_t  <= i_eval_time;
                r_ax <= '0;
                r_ay <= '0;
                r_az <= '0;
            end
            OP_CAP_LO: begin
                r_u0 <= r_ka;
                r_u1 <= r_kb;
            end
            OP_CAP_HI: begin
                r_u2 <= r_ka;
                r_u3 <= r_kb;
            end
            OP_RANGE:    r_in_range <= w_in_lo;
            OP_DIV_GO: begin
                r_b0 <= r_ba;
                r_b1 <= r_bb;
            end
            OP_MUL: begin
                r_p1 <= w_r1 * r_b0;
                r_p2 <= w_r2 * r_b1;
            end
            OP_TERM_MUL: begin
                r_mx <= r_px * r_ba;
                r_my <= r_py * r_ba;
                r_mz <= r_pz * r_ba;
            end
            OP_TERM_ACC: begin
                r_ax <= r_ax + w_tx[ACC_W-1:0];
                r_ay <= r_ay + w_ty[ACC_W-1:0];
                r_az <= r_az + w_tz[ACC_W-1:0];
            end
            default: ;
        endcase
    end

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        if (v > ACC_W'(32'sh7FFF_FFFF))      sat32 = 32'sh7FFF_FFFF;
        else if (v < ACC_W'(32'sh8000_0000)) sat32 = 32'sh8000_0000;
        else                                 sat32 = v[31:0];
    endfunction

    // output register, holds a finished beat while the next item runs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_op == OP_RESULT) begin
            r_out_valid <= 1'b1;
            r_out_rng   <= r_in_range;
            r_cx        <= r_in_range ? sat32(r_ax) : 32'sd0;
            r_cy        <= r_in_range ? sat32(r_ay) : 32'sd0;
            r_cz        <= r_in_range ? sat32(r_az) : 32'sd0;
        end else if (r_out_valid && i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.in_lo    = w_in_lo;
    assign o_status.div_busy = w_busy1 | w_busy2;
    assign o_status.out_full = r_out_valid;
    assign o_out_valid       = r_out_valid;
    assign o_curve_x         = r_cx;
    assign o_curve_y         = r_cy;
    assign o_curve_z         = r_cz;
    assign o_in_range        = r_out_rng;

endmodule

`default_nettype wire

### rtl/bspline_point_evaluation_core.sv
// Top level of the 3-D B-spline point evaluation core.
// Uses bpe_pkg, bpe_in_if, bpe_out_if, bpe_ctrl and bpe_datapath.
`default_nettype none

// Each input beat is a load (mode POINT writes control point x/y/z at index,
// mode KNOT writes one knot) or an evaluate (mode EVAL returns one curve point
// at eval_time, signed Q16.16, saturated). Loads give no beat; mode 3 is
// dropped. An evaluate checks u0 <= t < u(n+k) first: outside, it returns the
// zero point with in_range low. Inside, it builds the degree-0 basis (one
// entry per knot interval, n+k intervals), then runs the Cox-de Boor triangle
// one basis entry at a time, each entry waiting on the two 31-step ratio
// dividers working side by side, over sum(p=1..k) of (n+k-p) entries, then
// accumulates the weighted sum one control point at a time. One item is in
// flight at a time; the finished beat sits in an output register, so the
// next item is taken while it waits. Stores hold nothing valid until written;
// reading an unwritten slot gives an undefined result. Config writes (index 0
// degree, index 1 num_points) are only to be made while the core is idle.
module bspline_point_evaluation_core
    import bpe_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int MAX_DEGREE = MAX_DEGREE_DEF,
    localparam int KNOT_DEPTH = MAX_POINTS + MAX_DEGREE + 1,
    localparam int KW = $clog2(KNOT_DEPTH)
)(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_addr,
    input  wire logic [6:0] i_cfg_data,
    bpe_in_if.sink          i_in,
    bpe_out_if.source       o_out
);

    t_dp_status     w_status;
    t_dp_op         w_op;
    logic [KW-1:0]  w_ka, w_kb, w_j;
    logic           w_in_ready;

    assign i_in.ready = w_in_ready;

    bpe_ctrl #(
        .MAX_POINTS (MAX_POINTS),
        .MAX_DEGREE (MAX_DEGREE)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in.valid),
        .i_in_mode  (i_in.mode),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_op       (w_op),
        .o_ka       (w_ka),
        .o_kb       (w_kb),
        .o_j        (w_j)
    );

    bpe_datapath #(
        .MAX_POINTS (MAX_POINTS),
        .MAX_DEGREE (MAX_DEGREE)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (w_op),
        .i_ka         (w_ka),
        .i_kb         (w_kb),
        .i_j          (w_j),
        .i_mode       (i_in.mode),
        .i_index      (i_in.index),
        .i_point_x    (i_in.point_x),
        .i_point_y    (i_in.point_y),
        .i_point_z    (i_in.point_z),
        .i_knot_value (i_in.knot_value),
        .i_eval_time  (i_in.eval_time),
        .o_status     (w_status),
        .o_out_valid  (o_out.valid),
        .i_out_ready  (o_out.ready),
        .o_curve_x    (o_out.curve_x),
        .o_curve_y    (o_out.curve_y),
        .o_curve_z    (o_out.curve_z),
        .o_in_range   (o_out.in_range)
    );

endmodule

`default_nettype wire

### dv/bspline_point_evaluation_core_tb.sv
// Self-checking testbench for bspline_point_evaluation_core: loads, evaluates and config phases.
// Depends on bpe_pkg, bpe_in_if, bpe_out_if and the core RTL; a small scoreboard predicts each point.
`default_nettype none

module bspline_point_evaluation_core_tb;
    import bpe_pkg::*;

    localparam int NPTS_MAX  = 64;
    localparam int DEG_MAX   = 5;
    localparam int KNOTS_MAX = NPTS_MAX + DEG_MAX + 1;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 3000;

    typedef struct {
        logic        [1:0]  mode;
        logic        [6:0]  index;
        logic signed [31:0] x, y, z;
        logic        [31:0] knot_value;
        logic        [31:0] eval_time;
    } t_req;

    typedef struct {
        logic signed [31:0] x, y, z;
        logic               in_range;
    } t_curve_pt;

    // Mirror of the core: registers, stores, and points still owed.
    class curve_scoreboard;
        bit          [2:0]  degree;
        bit          [6:0]  npts;
        logic signed [31:0] px[NPTS_MAX], py[NPTS_MAX], pz[NPTS_MAX];
        bit          [31:0] knot[KNOTS_MAX];
        t_curve_pt          owed_q[$];
        int                 errors;

        function new();
            degree = 3;
            npts   = 4;
            errors = 0;
        endfunction

        function int eff_k();
            return (degree > DEG_MAX) ? DEG_MAX : degree;
        endfunction

        function int eff_n();
            return (npts == 0) ? 1 : ((npts > NPTS_MAX) ? NPTS_MAX : npts);
        endfunction

        function longint clamp_q30(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483647) return -64'sd2147483647;
            return v;
        endfunction

        function longint ratio_q30(longint num, longint den);
            if (den == 0) return 0;
            return clamp_q30((num <<< 30) / den);
        endfunction

        function logic signed [31:0] sat32(longint v);
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            return v[31:0];
        endfunction

        // Cox-de Boor triangle in Q.30 with the core's rounding and clamps
        function t_curve_pt curve_at(longint t);
            t_curve_pt pt;
            longint    bas[KNOTS_MAX];
            longint    uj, ujp, uj1, ujp1, r1, r2, acc, sx, sy, sz;
            int        k, n, nk;
            k  = eff_k();
            n  = eff_n();
            nk = n + k;
            pt = '{x: 0, y: 0, z: 0, in_range: 1'b0};
            if (!(longint'(knot[0]) <= t && t < longint'(knot[nk]))) return pt;
            for (int j = 0; j < nk; j++)
                bas[j] = (longint'(knot[j]) <= t && t < longint'(knot[j+1])) ? (64'sd1 <<< 30) : 0;
            for (int p = 1; p <= k; p++) begin
                for (int j = 0; j + p < nk; j++) begin
                    uj   = knot[j];
                    ujp  = knot[j+p];
                    uj1  = knot[j+1];
                    ujp1 = knot[j+p+1];
                    r1   = ratio_q30(t - uj, ujp - uj);
                    r2   = ratio_q30(ujp1 - t, ujp1 - uj1);
                    acc  = r1 * bas[j] + r2 * bas[j+1];
                    bas[j] = clamp_q30((acc + (64'sd1 <<< 29)) >>> 30);
                end
            end
            sx = 0; sy = 0; sz = 0;
            for (int j = 0; j < n; j++) begin
                sx += (longint'(px[j]) * bas[j] + (64'sd1 <<< 29)) >>> 30;
                sy += (longint'(py[j]) * bas[j] + (64'sd1 <<< 29)) >>> 30;
                sz += (longint'(pz[j]) * bas[j] + (64'sd1 <<< 29)) >>> 30;
            end
            pt.x = sat32(sx);
            pt.y = sat32(sy);
            pt.z = sat32(sz);
            pt.in_range = 1'b1;
            return pt;
        endfunction

        function void note_beat(t_req b);
            case (b.mode)
                MODE_POINT: if (b.index < NPTS_MAX) begin
                    px[b.index] = b.x;
                    py[b.index] = b.y;
                    pz[b.index] = b.z;
                end
                MODE_KNOT: if (b.index < KNOTS_MAX) knot[b.index] = b.knot_value;
                MODE_EVAL: owed_q = {owed_q, curve_at(longint'(b.eval_time))};
                default: ;
            endcase
        endfunction

        task report(string what);
            $display("mismatch @%0t: %s", $realtime, what);
            errors++;
        endtask

        task check_point(t_curve_pt got);
            t_curve_pt want;
            if (owed_q.size() == 0) begin
                report("output beat with no point owed");
                return;
            end
            want = owed_q.pop_front();
            if (got.x !== want.x) report($sformatf("x got %h want %h", got.x, want.x));
            if (got.y !== want.y) report($sformatf("y got %h want %h", got.y, want.y));
            if (got.z !== want.z) report($sformatf("z got %h want %h", got.z, want.z));
            if (got.in_range !== want.in_range)
                report($sformatf("in_range got %b want %b", got.in_range, want.in_range));
        endtask
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic       i_cfg_addr;
    logic [6:0] i_cfg_data;

    bpe_in_if  in_if ();
    bpe_out_if out_if ();

    bspline_point_evaluation_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    curve_scoreboard sb = new();

    bit offering;       // our own copy of in valid, since the NBA lands late
    int burst_left;
    bit hold_req;       // asks the receiver for one long hold-off

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // ---------------------------------------------------------------
    // Sender side. Beats come in bursts; a gap only drops valid when it
    // is non-zero, so valid never goes low and high in one step.
    // ---------------------------------------------------------------
    task send_beat(input t_req b);
        int gap;
        in_if.valid      <= 1'b1;
        in_if.mode       <= b.mode;
        in_if.index      <= b.index;
        in_if.point_x    <= b.x;
        in_if.point_y    <= b.y;
        in_if.point_z    <= b.z;
        in_if.knot_value <= b.knot_value;
        in_if.eval_time  <= b.eval_time;
        offering = 1'b1;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_beat(b);
        burst_left--;
        if (burst_left <= 0) begin
            // roughly a third of bursts run back to back
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                offering = 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Drop valid after the last beat of a phase and let the core drain.
    task drain();
        if (offering) begin
            in_if.valid <= 1'b0;
            offering = 1'b0;
        end
        @(posedge i_clk);
        while (sb.owed_q.size() != 0) @(posedge i_clk);
        // loads give no beat; leave time for anything still in flight
        repeat (40) @(posedge i_clk);
    endtask

    task write_reg(input t_cfg_reg r, input bit [6:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= r;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (r == CFG_DEGREE) sb.degree = v[2:0];
        else sb.npts = v;
    endtask

    // every field random so that unused fields toggle all their bits too
    function t_req noise_req(logic [1:0] mode, logic [6:0] idx);
        t_req b;
        b.mode       = mode;
        b.index      = idx;
        b.x          = $urandom;
        b.y          = $urandom;
        b.z          = $urandom;
        b.knot_value = $urandom;
        b.eval_time  = $urandom;
        return b;
    endfunction

    function logic signed [31:0] point_val();
        case ($urandom_range(0, 9))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 32'sh0000_0000;
            3: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            default: return $urandom;
        endcase
    endfunction

    // Mostly inside the knot range; knot edges, just below u0, and wild t as well.
    function logic [31:0] pick_time();
        longint lo, hi;
        int     nk;
        nk = sb.eff_n() + sb.eff_k();
        lo = sb.knot[0];
        hi = sb.knot[nk];
        case ($urandom_range(0, 11))
            0: return $urandom;
            1: return (lo > 0) ? 32'(lo - 1) : 32'(hi);
            2: return 32'(hi);
            3: return 32'(lo);
            4: return sb.knot[$urandom_range(0, nk)];
            5: return 32'hFFFF_FFFF;
            default: begin
                if (hi > lo) return 32'(lo + longint'($urandom) % (hi - lo));
                return $urandom;
            end
        endcase
    endfunction

    task send_point(int idx);
        t_req b;
        b = noise_req(MODE_POINT, idx);
        b.x = point_val();
        b.y = point_val();
        b.z = point_val();
        send_beat(b);
    endtask

    task send_knot(int idx, logic [31:0] v);
        t_req b;
        b = noise_req(MODE_KNOT, idx);
        b.knot_value = v;
        send_beat(b);
    endtask

    task send_eval(logic [31:0] t);
        t_req b;
        b = noise_req(MODE_EVAL, $urandom_range(0, 127));
        b.eval_time = t;
        send_beat(b);
    endtask

    // Knot vector for the active span, in one of several shapes.
    task load_knots(int shape);
        int          nk, k;
        logic [31:0] u;
        nk = sb.eff_n() + sb.eff_k();
        k  = sb.eff_k();
        u  = (shape == 3) ? 32'hFFFF_FFFF - nk * 32'h100 : $urandom_range(0, 32'h0010_0000);
        for (int j = 0; j <= nk; j++) begin
            case (shape)
                0: u = j * 32'h0001_0000;                        // uniform, unit step
                1: if (j > 0 && $urandom_range(0, 3) != 0)      // random steps, some repeated
                       u = u + $urandom_range(1, 32'h0002_0000);
                2: if (j > k && j <= nk - k) u = u + 32'h0001_0000; // clamped ends
                3: if (j > 0) u = u + 32'h100;                  // at the top of the range
                default: u = $urandom;                          // non-monotone
            endcase
            send_knot(j, u);
        end
    endtask

    // One random beat: mostly evaluates and legal loads, some noise.
    task random_beat();
        int          r, idx;
        longint      lo, hi;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            send_eval(pick_time());
        end else if (r < 62) begin
            idx = $urandom_range(0, KNOTS_MAX - 1);
            lo = (idx > 0) ? sb.knot[idx-1] : 0;
            hi = (idx < KNOTS_MAX - 1) ? sb.knot[idx+1] : 64'hFFFF_FFFF;
            if (hi >= lo && $urandom_range(0, 4) != 0)
                send_knot(idx, 32'(lo + longint'($urandom) % (hi - lo + 1)));
            else
                send_knot(idx, $urandom);
        end else if (r < 80) begin
            send_point($urandom_range(0, NPTS_MAX - 1));
        end else if (r < 88) begin
            send_point($urandom_range(NPTS_MAX, 127));         // dropped by the core
        end else if (r < 94) begin
            send_knot($urandom_range(KNOTS_MAX, 127), $urandom);
        end else begin
            send_beat(noise_req(MODE_UNUSED, $urandom_range(0, 127)));
        end
    endtask

    // ---------------------------------------------------------------
    // Receiver side: its own stall pattern, plus one long hold-off when
    // asked, so that the core fills up and back-pressures its input.
    // ---------------------------------------------------------------
    initial begin
        int cyc;
        cyc = 0;
        out_if.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                cyc++;
                case ((cyc / 400) % 3)
                    0: out_if.ready <= 1'b1;
                    1: out_if.ready <= ($urandom_range(0, 3) != 0);
                    default: out_if.ready <= (cyc % 5 == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            sb.check_point('{x: out_if.curve_x, y: out_if.curve_y,
                             z: out_if.curve_z, in_range: out_if.in_range});
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        // degree, num_points, random beats; out-of-range settings are clamped by the core
        int phase_deg[10]  = '{3, 0, 1, 2, 5, 7, 4, 0, 5, 3};
        int phase_npts[10] = '{4, 1, 2, 7, 64, 127, 0, 64, 10, 4};
        int phase_len[10]  = '{180, 160, 160, 180, 12, 4, 80, 100, 110, 130};

        in_if.valid      <= 1'b0;
        in_if.mode       <= MODE_POINT;
        in_if.index      <= '0;
        in_if.point_x    <= '0;
        in_if.point_y    <= '0;
        in_if.point_z    <= '0;
        in_if.knot_value <= '0;
        in_if.eval_time  <= '0;
        i_cfg_we         <= 1'b0;
        i_cfg_addr       <= CFG_DEGREE;
        i_cfg_data       <= '0;
        i_rst_n          <= 1'b0;
        offering   = 1'b0;
        hold_req   = 1'b0;
        burst_left = $urandom_range(1, 24);
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill every store slot once so that no read ever finds an unwritten entry.
        for (int j = 0; j < NPTS_MAX; j++) send_point(j);
        for (int j = 0; j < KNOTS_MAX; j++) send_knot(j, j * 32'h0001_0000);

        // Directed: extremes of t, the knot edges, saturating points, dropped beats.
        send_point(0);
        send_eval(0);                       // t at u0: in range, yet every basis value is zero there
        send_eval(32'h0000_8000);
        send_eval(32'h0007_0000);           // t = u(n+k): half-open, out of range
        send_eval(32'h0006_FFFF);
        send_eval(32'hFFFF_FFFF);
        send_knot(0, 32'h0000_0001);
        send_eval(0);                       // below u0
        send_knot(0, 0);
        send_point(NPTS_MAX);               // control point slot past the store
        send_point(127);
        send_knot(KNOTS_MAX, $urandom);     // knot slot past the store
        send_knot(127, $urandom);
        send_beat(noise_req(MODE_UNUSED, 7'h7F));
        send_knot(2, 32'h0001_0000);        // zero-length span in the middle
        send_eval(32'h0001_0000);
        send_eval(32'h0000_FFFF);
        send_knot(2, 32'h0002_0000);
        send_eval(32'h0003_8000);
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            write_reg(CFG_DEGREE, phase_deg[ph]);
            write_reg(CFG_NUM_POINTS, phase_npts[ph]);
            load_knots((ph == 9) ? 4 : ph % 4);
            // cheap evaluates here, so a long hold-off stalls the input
            if (ph == 1) hold_req = 1'b1;
            for (int i = 0; i < phase_len[ph]; i++) random_beat();
            drain();
        end

        while (sb.owed_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0 && sb.owed_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #(8 * 8_000_000);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
rtl/bpe_pkg.sv
rtl/bpe_in_if.sv
rtl/bpe_out_if.sv
rtl/bpe_div.sv
rtl/bpe_ctrl.sv
rtl/bpe_datapath.sv
rtl/bspline_point_evaluation_core.sv
dv/bspline_point_evaluation_core_tb.sv
